// ===== hdl/idf1_pkg.sv =====
// ----------------------------------------------------------------------------
// idf1_pkg: shared types and microcode for the direct form I IIR filter
// Payload types, micro-op codes and the sequencer program.
// ----------------------------------------------------------------------------
package idf1_pkg;

  localparam int XW     = 16;
  localparam int YW     = 32;
  localparam int CW     = 32;
  localparam int IW     = 4;
  localparam int STEP_W = 3;

  typedef logic signed [XW-1:0] sample_t;
  typedef logic signed [YW-1:0] result_t;
  typedef logic signed [CW-1:0] coef_t;
  typedef logic [IW-1:0]        coef_idx_t;
  typedef logic [STEP_W-1:0]    step_t;

  localparam logic [2:0] UOP_WAIT = 3'd0;
  localparam logic [2:0] UOP_B0   = 3'd1;
  localparam logic [2:0] UOP_BK   = 3'd2;
  localparam logic [2:0] UOP_AK   = 3'd3;
  localparam logic [2:0] UOP_NOP  = 3'd4;
  localparam logic [2:0] UOP_DONE = 3'd5;

  localparam logic [1:0] J_NEXT   = 2'd0;
  localparam logic [1:0] J_ALWAYS = 2'd1;
  localparam logic [1:0] J_LOOP   = 2'd2;
  localparam logic [1:0] J_START  = 2'd3;

  localparam step_t STEP_IDLE  = 3'd0;
  localparam step_t STEP_FIRST = 3'd1;
  localparam step_t STEP_BK    = 3'd2;
  localparam step_t STEP_DONE  = 3'd6;

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] jump;
    step_t      target;
  } uword_t;

  localparam int UC_DEPTH = 2 ** STEP_W;

  localparam uword_t UCODE [UC_DEPTH] = '{
    '{op: UOP_WAIT, jump: J_START,  target: STEP_FIRST},
    '{op: UOP_B0,   jump: J_NEXT,   target: STEP_IDLE},
    '{op: UOP_BK,   jump: J_NEXT,   target: STEP_IDLE},
    '{op: UOP_AK,   jump: J_LOOP,   target: STEP_BK},
    '{op: UOP_NOP,  jump: J_NEXT,   target: STEP_IDLE},
    '{op: UOP_NOP,  jump: J_NEXT,   target: STEP_IDLE},
    '{op: UOP_DONE, jump: J_ALWAYS, target: STEP_IDLE},
    '{op: UOP_NOP,  jump: J_ALWAYS, target: STEP_IDLE}
  };

endpackage

// ===== hdl/idf1_req_if.sv =====
// ----------------------------------------------------------------------------
// idf1_req_if: request channel
// Valid/ready channel carrying a sample item or a coefficient write item.
// ----------------------------------------------------------------------------
interface idf1_req_if;
  logic                valid;
  logic                ready;
  logic                req_type;
  idf1_pkg::sample_t   sample_in;
  idf1_pkg::coef_idx_t coef_index;
  idf1_pkg::coef_t     coef_value;

  modport source (
    output valid, req_type, sample_in, coef_index, coef_value,
    input  ready
  );

  modport sink (
    input  valid, req_type, sample_in, coef_index, coef_value,
    output ready
  );
endinterface

// ===== hdl/idf1_rsp_if.sv =====
// ----------------------------------------------------------------------------
// idf1_rsp_if: result channel
// Valid/ready channel carrying one filter output item.
// ----------------------------------------------------------------------------
interface idf1_rsp_if;
  logic              valid;
  logic              ready;
  idf1_pkg::result_t filtered_out;
  logic              saturated;

  modport source (
    output valid, filtered_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, filtered_out, saturated,
    output ready
  );
endinterface

// ===== hdl/iir_direct_form_one_filter.sv =====
// ----------------------------------------------------------------------------
// iir_direct_form_one_filter: microcoded direct form I IIR filter
// Coefficient writes and samples share one request channel; each sample
// yields one saturated Q24.8 output through a shared multiply-accumulate.
//
//   channel  dir  payload                                        handshake
//   req      in   req_type, sample_in, coef_index, coef_value    valid/ready
//   rsp      out  filtered_out, saturated                        valid/ready
//
// A coefficient write item leaves the sequencer in its idle step.
// A sample item issues one multiply-accumulate per coefficient through the
// single multiplier, then runs the NOP steps that drain the pipeline and
// one round/saturate step before the sequencer returns to its idle step.
// Reset clears histories, coefficient valid bits and all control at once.
// A stalled rsp holds the sequencer on its final step; req is ready only
// while the sequencer waits in its idle step.
// ----------------------------------------------------------------------------
module iir_direct_form_one_filter #(
  parameter int ORDER = 4
) (
  input logic         clk,
  input logic         rst,
  idf1_req_if.sink    req,
  idf1_rsp_if.source  rsp
);
  import idf1_pkg::*;

  localparam int NCOEF = 2 * ORDER + 1;
  localparam int CAW   = $clog2(NCOEF);
  localparam int KW    = (ORDER > 1) ? $clog2(ORDER) : 1;
  localparam logic [KW-1:0] K_LAST = KW'(ORDER - 1);

  coef_t          coef_mem [NCOEF];
  logic [NCOEF-1:0] coef_ok;
  sample_t        xh [ORDER];
  result_t        yh [ORDER];

  step_t          step;
  step_t          step_next;
  uword_t         uw;
  logic [KW-1:0]  k;
  sample_t        x;

  logic           accept;
  logic           start;
  logic           wr_acc;
  logic [31:0]    wr_idx_w;
  logic [CAW-1:0] wr_addr;
  logic           wr_hit;
  logic [CAW-1:0] rd_addr;
  logic           issue;
  logic           hold;
  logic           finish;
  logic signed [31:0] opnd_sel;

  logic           s1_v;
  logic           s1_fb;
  logic           s1_ok;
  coef_t          s1_coef;
  logic signed [31:0] s1_opnd;
  coef_t          coef_eff;
  logic           s2_v;
  logic           s2_fb;
  logic signed [63:0] prod;
  logic signed [63:0] acc;
  logic signed [63:0] rnd;
  result_t        y_sat;
  logic           y_clip;

  logic           out_valid;
  result_t        y_out;
  logic           sat_out;

  assign uw       = UCODE[step];
  assign req.ready = (step == STEP_IDLE);
  assign accept   = req.valid && req.ready;
  assign start    = accept && !req.req_type;
  assign wr_acc   = accept && req.req_type;
  assign wr_idx_w = 32'(req.coef_index);
  assign wr_addr  = wr_idx_w[CAW-1:0];
  assign wr_hit   = (wr_idx_w < 32'(NCOEF));
  assign issue    = (uw.op == UOP_B0) || (uw.op == UOP_BK) || (uw.op == UOP_AK);
  assign hold     = (uw.op == UOP_DONE) && out_valid && !rsp.ready;
  assign finish   = (uw.op == UOP_DONE) && !hold;
  assign coef_eff = s1_ok ? s1_coef : '0;

  always_comb begin
    rd_addr  = '0;
    opnd_sel = 32'(x);
    unique case (uw.op)
      UOP_BK: begin
        rd_addr  = CAW'(k) + CAW'(1);
        opnd_sel = 32'(xh[k]);
      end
      UOP_AK: begin
        rd_addr  = CAW'(ORDER + 1) + CAW'(k);
        opnd_sel = yh[k];
      end
      default: begin
        rd_addr  = '0;
        opnd_sel = 32'(x);
      end
    endcase
  end

  always_comb begin
    step_next = step;
    unique case (uw.jump)
      J_NEXT:   step_next = step + STEP_W'(1);
      J_ALWAYS: if (!hold) step_next = uw.target;
      J_LOOP:   step_next = (k != K_LAST) ? uw.target : step + STEP_W'(1);
      J_START:  if (start) step_next = uw.target;
    endcase
  end

  always_comb begin
    rnd    = (acc + 64'sd524288) >>> 20;
    y_clip = 1'b1;
    priority if (rnd > 64'sh0000_0000_7FFF_FFFF) begin
      y_sat = 32'sh7FFF_FFFF;
    end else if (rnd < 64'shFFFF_FFFF_8000_0000) begin
      y_sat = 32'sh8000_0000;
    end else begin
      y_sat  = rnd[31:0];
      y_clip = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= STEP_IDLE;
      k         <= '0;
      s1_v      <= 1'b0;
      s2_v      <= 1'b0;
      out_valid <= 1'b0;
      coef_ok   <= '0;
      for (int i = 0; i < ORDER; i++) begin
        xh[i] <= '0;
        yh[i] <= '0;
      end
    end else begin
      step <= step_next;
      s1_v <= issue;
      s2_v <= s1_v;
      if (start) begin
        k <= '0;
      end else if ((uw.jump == J_LOOP) && (k != K_LAST)) begin
        k <= k + KW'(1);
      end
      if (wr_acc && wr_hit) begin
        coef_ok[wr_addr] <= 1'b1;
      end
      if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      if (finish) begin
        out_valid <= 1'b1;
        for (int i = ORDER - 1; i > 0; i--) begin
          xh[i] <= xh[i-1];
          yh[i] <= yh[i-1];
        end
        xh[0] <= x;
        yh[0] <= y_sat;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr_acc && wr_hit) begin
      coef_mem[wr_addr] <= req.coef_value;
    end
    s1_coef <= coef_mem[rd_addr];
    s1_ok   <= coef_ok[rd_addr];
    s1_opnd <= opnd_sel;
    s1_fb   <= (uw.op == UOP_AK);
    prod    <= coef_eff * s1_opnd;
    s2_fb   <= s1_fb;
    if (start) begin
      x   <= req.sample_in;
      acc <= '0;
    end else if (s2_v) begin
      acc <= s2_fb ? (acc - (prod >>> 8)) : (acc + prod);
    end
    if (finish) begin
      y_out   <= y_sat;
      sat_out <= y_clip;
    end
  end

  assign rsp.valid        = out_valid;
  assign rsp.filtered_out = y_out;
  assign rsp.saturated    = sat_out;

  a_pipe_empty_idle: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_IDLE) |-> (!s1_v && !s2_v))
    else $error("multiply pipeline busy while sequencer idle");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(step) == STEP_DONE))
    else $error("result raised outside the final step");

  a_loop_start: assert property (@(posedge clk) disable iff (rst)
    (step == STEP_FIRST) |-> (k == '0))
    else $error("tap counter not cleared at sample start");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rsp.saturated) |->
      ((rsp.filtered_out == 32'sh7FFF_FFFF) || (rsp.filtered_out == 32'sh8000_0000)))
    else $error("saturated flag with an unclipped value");

endmodule

// ===== verif/tb_iir_direct_form_one_filter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_iir_direct_form_one_filter: testbench for the direct form I IIR filter
// The testbench first loads coefficients and sends samples to cover the field
// extremes, writes to unused slots and saturation in both directions. It then
// sends random coefficient sets, each followed by a random run of samples.
// A fixed point copy of the filter predicts every output, and each output is
// checked field by field. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
module tb_iir_direct_form_one_filter;
  import idf1_pkg::*;

  localparam int FILTER_ORDER = 4;
  localparam int NUM_COEFS    = 2 * FILTER_ORDER + 1;
  localparam int MAX_SLOT     = 2 ** IW - 1;
  localparam int RANDOM_ITEMS = 1050;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_NS     = 4_000_000;

  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_COEF   = 1'b1;

  localparam longint Y_MAX = 64'sd2147483647;
  localparam longint Y_MIN = -64'sd2147483648;

  localparam int STYLE_STABLE  = 0;
  localparam int STYLE_WIDE    = 1;
  localparam int STYLE_EXTREME = 2;
  localparam int STYLE_MIXED   = 3;

  typedef struct {
    logic      pause;
    logic      req_type;
    sample_t   sample;
    coef_idx_t index;
    coef_t     value;
  } filter_req_t;

  typedef struct {
    result_t value;
    logic    clipped;
  } filter_out_t;

  logic clk;
  logic rst;

  idf1_req_if req_ch ();
  idf1_rsp_if rsp_ch ();

  iir_direct_form_one_filter #(.ORDER(FILTER_ORDER)) u_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  sample_t     x_hist [FILTER_ORDER];
  result_t     y_hist [FILTER_ORDER];
  coef_t       coef_store [NUM_COEFS];
  filter_req_t pending_reqs [$];
  filter_out_t expected_outputs [$];

  int unsigned issued     = 0;
  int unsigned accepted   = 0;
  int unsigned burst_left = 0;
  int unsigned gap_left   = 0;
  int unsigned stall_left = 0;
  int unsigned stall_mode = 0;
  int unsigned rx_cycle   = 0;
  int          errors     = 0;
  int          valid_items = 0;

  function automatic filter_out_t filter_sample(input sample_t x);
    filter_out_t r;
    longint acc;
    longint yq;
    acc = longint'(coef_store[0]) * longint'(x);
    for (int k = 0; k < FILTER_ORDER; k++) begin
      acc += longint'(coef_store[k + 1]) * longint'(x_hist[k]);
      acc -= (longint'(coef_store[FILTER_ORDER + 1 + k]) * longint'(y_hist[k])) >>> 8;
    end
    yq = (acc + (longint'(1) << 19)) >>> 20;
    r.clipped = 1'b1;
    if (yq > Y_MAX) begin
      r.value = result_t'(Y_MAX);
    end else if (yq < Y_MIN) begin
      r.value = result_t'(Y_MIN);
    end else begin
      r.value   = result_t'(yq);
      r.clipped = 1'b0;
    end
    for (int k = FILTER_ORDER - 1; k > 0; k--) begin
      x_hist[k] = x_hist[k - 1];
      y_hist[k] = y_hist[k - 1];
    end
    x_hist[0] = x;
    y_hist[0] = r.value;
    return r;
  endfunction

  function automatic coef_t random_coef(input int style, input logic feedback);
    int pick;
    int span;
    pick = (style == STYLE_MIXED) ? $urandom_range(STYLE_STABLE, STYLE_EXTREME) : style;
    span = feedback ? (1 << 25) : (1 << 28);
    case (pick)
      STYLE_STABLE: begin
        return coef_t'(int'($urandom_range(0, 2 * span)) - span);
      end
      STYLE_EXTREME: begin
        case ($urandom_range(0, 6))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh1000_0000;
          3: return 32'shF000_0000;
          4: return 32'sh0000_0001;
          5: return 32'shFFFF_FFFF;
          default: return '0;
        endcase
      end
      default: begin
        return coef_t'($urandom);
      end
    endcase
  endfunction

  function automatic sample_t random_sample();
    case ($urandom_range(0, 7))
      0: return $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
      1: return sample_t'(int'($urandom_range(0, 128)) - 64);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic push_coef(input int slot, input coef_t value);
    filter_req_t r;
    r.pause    = 1'b0;
    r.req_type = REQ_COEF;
    r.sample   = sample_t'($urandom);
    r.index    = coef_idx_t'(slot);
    r.value    = value;
    pending_reqs.push_back(r);
    if (slot < NUM_COEFS) valid_items++;
  endtask

  task automatic push_sample(input sample_t x);
    filter_req_t r;
    r.pause    = 1'b0;
    r.req_type = REQ_SAMPLE;
    r.sample   = x;
    r.index    = coef_idx_t'($urandom);
    r.value    = coef_t'($urandom);
    pending_reqs.push_back(r);
    valid_items++;
  endtask

  task automatic push_pause();
    filter_req_t r;
    r = '{pause: 1'b1, req_type: REQ_SAMPLE, sample: '0, index: '0, value: '0};
    pending_reqs.push_back(r);
  endtask

  initial begin
    clk               = 1'b0;
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.req_type   = REQ_SAMPLE;
    req_ch.sample_in  = '0;
    req_ch.coef_index = '0;
    req_ch.coef_value = '0;
    rsp_ch.ready      = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("tb_iir_direct_form_one_filter: done, errors");
    $finish;
  end

  // update the model on every accepted item and predict each sample's output
  always @(posedge clk) begin
    if (rst) begin
      accepted <= 0;
      for (int k = 0; k < FILTER_ORDER; k++) begin
        x_hist[k] = '0;
        y_hist[k] = '0;
      end
      for (int k = 0; k < NUM_COEFS; k++) coef_store[k] = '0;
    end else if (req_ch.valid && req_ch.ready) begin
      accepted <= accepted + 1;
      if (req_ch.req_type == REQ_COEF) begin
        if (req_ch.coef_index < NUM_COEFS) coef_store[req_ch.coef_index] = req_ch.coef_value;
      end else begin
        expected_outputs.push_back(filter_sample(req_ch.sample_in));
      end
    end
  end

  always @(posedge clk) begin : monitor
    filter_out_t want;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (expected_outputs.size() == 0) begin
        errors++;
        $display("%0t: unexpected item, actual filtered_out %0d saturated %0b",
                 $time, rsp_ch.filtered_out, rsp_ch.saturated);
      end else begin
        want = expected_outputs.pop_front();
        if (rsp_ch.filtered_out !== want.value) begin
          errors++;
          $display("%0t: filtered_out expected %0d actual %0d",
                   $time, want.value, rsp_ch.filtered_out);
        end
        if (rsp_ch.saturated !== want.clipped) begin
          errors++;
          $display("%0t: saturated expected %0b actual %0b",
                   $time, want.clipped, rsp_ch.saturated);
        end
      end
    end
  end

  always @(negedge clk) begin : driver
    filter_req_t nxt;
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else if (req_ch.valid && accepted != issued) begin
      // hold until accepted
    end else if (gap_left > 0) begin
      req_ch.valid <= 1'b0;
      gap_left     <= gap_left - 1;
    end else if (pending_reqs.size() > 0 && pending_reqs[0].pause) begin
      req_ch.valid <= 1'b0;
      if (expected_outputs.size() == 0) void'(pending_reqs.pop_front());
    end else if (pending_reqs.size() > 0) begin
      nxt = pending_reqs.pop_front();
      req_ch.valid      <= 1'b1;
      req_ch.req_type   <= nxt.req_type;
      req_ch.sample_in  <= nxt.sample;
      req_ch.coef_index <= nxt.index;
      req_ch.coef_value <= nxt.value;
      issued            <= issued + 1;
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 24);
        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      req_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin : receiver
    rx_cycle <= rx_cycle + 1;
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode <= $urandom_range(0, 3);
        stall_left <= $urandom_range(50, 400);
      end else begin
        stall_left <= stall_left - 1;
      end
      case (stall_mode)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(0, 1));
        2: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
        default: rsp_ch.ready <= (rx_cycle % 16) >= 11;
      endcase
    end
  end

  initial begin : stimulus
    int style;
    int batch;
    int n;

    push_sample(16'sh7FFF);
    push_coef(0, 32'sh1000_0000);
    push_sample(16'sh8000);
    push_sample(16'sh7FFF);
    push_sample(16'sh0001);
    push_sample(16'shFFFF);
    push_coef(1, 32'sh7FFF_FFFF);
    push_coef(FILTER_ORDER, 32'sh8000_0000);
    push_coef(FILTER_ORDER + 1, 32'sh0800_0000);
    push_coef(NUM_COEFS - 1, 32'shF800_0000);
    push_coef(NUM_COEFS, 32'sh7FFF_FFFF);
    push_coef(MAX_SLOT, 32'shFFFF_FFFF);
    push_pause();
    push_sample(16'sd100);
    push_sample(-16'sd100);
    push_sample(16'sh7FFF);
    push_coef(0, 32'sh7FFF_FFFF);
    push_coef(FILTER_ORDER + 1, 32'sh7FFF_FFFF);
    repeat (6) push_sample(16'sh7FFF);
    push_pause();

    while (valid_items < RANDOM_ITEMS) begin
      style = $urandom_range(STYLE_STABLE, STYLE_MIXED);
      n = ($urandom_range(0, 3) == 0) ? $urandom_range(1, NUM_COEFS) : NUM_COEFS;
      for (int i = 0; i < n; i++) begin
        push_coef(i, random_coef(style, i > FILTER_ORDER));
      end
      if ($urandom_range(0, 2) == 0) push_coef($urandom_range(NUM_COEFS, MAX_SLOT), $urandom);
      batch = $urandom_range(8, 48);
      repeat (batch) begin
        n = $urandom_range(0, 39);
        if (n < 2) begin
          n = $urandom_range(0, NUM_COEFS - 1);
          push_coef(n, random_coef(style, n > FILTER_ORDER));
        end else if (n == 2) begin
          push_coef($urandom_range(NUM_COEFS, MAX_SLOT), $urandom);
        end else begin
          push_sample(random_sample());
        end
      end
      if ($urandom_range(0, 5) == 0) push_pause();
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || accepted != issued || expected_outputs.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_iir_direct_form_one_filter: done, clean");
    end else begin
      $display("tb_iir_direct_form_one_filter: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/idf1_pkg.sv
hdl/idf1_req_if.sv
hdl/idf1_rsp_if.sv
hdl/iir_direct_form_one_filter.sv
verif/tb_iir_direct_form_one_filter.sv
